// File: hw/rtl/aabb_affine_transform_assert.svh
// Assertion macros for the box transform pipeline
`ifndef AABB_AFFINE_TRANSFORM_ASSERT_SVH
`define AABB_AFFINE_TRANSFORM_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define AABB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define AABB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/aabb_pkg.sv
// Shared types, constants and helpers for the box transform pipeline
`default_nettype none
package aabb_pkg;

  // Field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned ROW_W   = 3 * COEF_W;
  localparam int unsigned PROD_W  = COORD_W + COEF_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned SH_W    = SUM_W - FRAC_W;
  localparam int unsigned ADD_W   = SH_W + 1;
  localparam int unsigned CFG_IDX_W = 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [ROW_W-1:0]   coef_row_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [ADD_W-1:0]   add_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = CFG_IDX_W'(5);

  // Reset values: identity matrix (1.0 in Q4.12), zero translation
  localparam coef_row_t ROW_X_RST = ROW_W'(48'h0000_0000_1000);
  localparam coef_row_t ROW_Y_RST = ROW_W'(48'h0000_1000_0000);
  localparam coef_row_t ROW_Z_RST = ROW_W'(48'h1000_0000_0000);

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Per-stage load enables of one axis lane
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } aabb_stage_en_t;

  typedef struct packed {
    coord_t val;
    logic   sat;
  } clamp_res_t;

  // Clamp to signed 32 bits, flag when clipped
  function automatic clamp_res_t clamp_coord(input add_t v);
    clamp_res_t r;
    r.sat = (v > ADD_W'(COORD_MAX)) || (v < ADD_W'(COORD_MIN));
    if (v > ADD_W'(COORD_MAX)) begin
      r.val = COORD_MAX;
    end else if (v < ADD_W'(COORD_MIN)) begin
      r.val = COORD_MIN;
    end else begin
      r.val = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/aabb_affine_transform.sv
// Top level: register file, pipeline valid/stall control and three axis lanes
// Stages from request accept to out_valid: product, sort, sum, clamp.
// Throughput: one request per cycle; each stage holds when the stage after it is full
// and stalled, so a request can enter while a finished result waits at the output.
// Reset (rst_n low, synchronous): pipeline emptied, registers back to the identity
// matrix and zero translation.
`default_nettype none
module aabb_affine_transform
  import aabb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ROW_W-1:0]     cfg_wdata,
  // input requests
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire coord_t               in_min_x,
  input  wire coord_t               in_min_y,
  input  wire coord_t               in_min_z,
  input  wire coord_t               in_max_x,
  input  wire coord_t               in_max_y,
  input  wire coord_t               in_max_z,
  // results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output coord_t                    out_min_x,
  output coord_t                    out_min_y,
  output coord_t                    out_min_z,
  output coord_t                    out_max_x,
  output coord_t                    out_max_y,
  output coord_t                    out_max_z,
  output logic                      out_saturated
);

  // Configuration registers
  coef_row_t row_x_r, row_y_r, row_z_r;
  coord_t    shift_x_r, shift_y_r, shift_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r   <= ROW_X_RST;
      row_y_r   <= ROW_Y_RST;
      row_z_r   <= ROW_Z_RST;
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROW_X:   row_x_r   <= cfg_wdata;
        REG_ROW_Y:   row_y_r   <= cfg_wdata;
        REG_ROW_Z:   row_z_r   <= cfg_wdata;
        REG_SHIFT_X: shift_x_r <= cfg_wdata[COORD_W-1:0];
        REG_SHIFT_Y: shift_y_r <= cfg_wdata[COORD_W-1:0];
        REG_SHIFT_Z: shift_z_r <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when empty or when its successor moves
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;
  aabb_stage_en_t en;

  assign rdy4 = !v4_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r     : v2_r;
  assign v3_nxt = rdy3 ? v2_r     : v3_r;
  assign v4_nxt = rdy4 ? v3_r     : v4_r;

  assign en.en1 = rdy1 && in_valid;
  assign en.en2 = rdy2 && v1_r;
  assign en.en3 = rdy3 && v2_r;
  assign en.en4 = rdy4 && v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  assign in_stall  = !rdy1;
  assign out_valid = v4_r;

  // Corner values shared by all lanes
  coord_t lo [3];
  coord_t hi [3];
  assign lo[0] = in_min_x;
  assign lo[1] = in_min_y;
  assign lo[2] = in_min_z;
  assign hi[0] = in_max_x;
  assign hi[1] = in_max_y;
  assign hi[2] = in_max_z;

  logic sat_x, sat_y, sat_z;

  // One lane per output axis
  aabb_axis_pipe u_axis_x (
    .clk      (clk),
    .en       (en),
    .coef_row (row_x_r),
    .shift    (shift_x_r),
    .lo       (lo),
    .hi       (hi),
    .res_min  (out_min_x),
    .res_max  (out_max_x),
    .res_sat  (sat_x)
  );

  aabb_axis_pipe u_axis_y (
    .clk      (clk),
    .en       (en),
    .coef_row (row_y_r),
    .shift    (shift_y_r),
    .lo       (lo),
    .hi       (hi),
    .res_min  (out_min_y),
    .res_max  (out_max_y),
    .res_sat  (sat_y)
  );

  aabb_axis_pipe u_axis_z (
    .clk      (clk),
    .en       (en),
    .coef_row (row_z_r),
    .shift    (shift_z_r),
    .lo       (lo),
    .hi       (hi),
    .res_min  (out_min_z),
    .res_max  (out_max_z),
    .res_sat  (sat_z)
  );

  assign out_saturated = sat_x | sat_y | sat_z;

  // Checks
  `include "aabb_affine_transform_assert.svh"

  `AABB_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, v1_r, "accepted request lost at stage 1")
  `AABB_ASSERT_NOW(a_box_ordered, out_valid, (out_min_x <= out_max_x) && (out_min_y <= out_max_y) && (out_min_z <= out_max_z), "result box not ordered")
  `AABB_ASSERT_NOW(a_sat_at_limit, out_valid && out_saturated, (out_min_x == COORD_MAX) || (out_min_x == COORD_MIN) || (out_max_x == COORD_MAX) || (out_max_x == COORD_MIN) || (out_min_y == COORD_MAX) || (out_min_y == COORD_MIN) || (out_max_y == COORD_MAX) || (out_max_y == COORD_MIN) || (out_min_z == COORD_MAX) || (out_min_z == COORD_MIN) || (out_max_z == COORD_MAX) || (out_max_z == COORD_MIN), "saturation flagged without a clamped value")

endmodule
`default_nettype wire

// File: hw/rtl/aabb_axis_pipe.sv
// One output axis: products, min/max term sort, sum, floor shift, translate, clamp
`default_nettype none
module aabb_axis_pipe
  import aabb_pkg::*;
(
  input  wire logic           clk,
  input  wire aabb_stage_en_t en,
  input  wire coef_row_t      coef_row,
  input  wire coord_t         shift,
  input  wire coord_t         lo [3],
  input  wire coord_t         hi [3],
  output coord_t              res_min,
  output coord_t              res_max,
  output logic                res_sat
);

  prod_t  prod_lo_r [3];
  prod_t  prod_hi_r [3];
  prod_t  term_min_r [3];
  prod_t  term_max_r [3];
  sum_t   sum_min_r;
  sum_t   sum_max_r;
  coord_t res_min_r;
  coord_t res_max_r;
  logic   res_sat_r;

  // Stage 1: coefficient times both corner values
  for (genvar j = 0; j < 3; j++) begin : g_term
    logic signed [COEF_W-1:0] coef;
    prod_t prod_lo_nxt;
    prod_t prod_hi_nxt;

    assign coef        = $signed(coef_row[j*COEF_W +: COEF_W]);
    assign prod_lo_nxt = coef * lo[j];
    assign prod_hi_nxt = coef * hi[j];

    always_ff @(posedge clk) begin
      if (en.en1) begin
        prod_lo_r[j] <= prod_lo_nxt;
        prod_hi_r[j] <= prod_hi_nxt;
      end
    end

    // Stage 2: order the two products of this term
    always_ff @(posedge clk) begin
      if (en.en2) begin
        if (prod_lo_r[j] < prod_hi_r[j]) begin
          term_min_r[j] <= prod_lo_r[j];
          term_max_r[j] <= prod_hi_r[j];
        end else begin
          term_min_r[j] <= prod_hi_r[j];
          term_max_r[j] <= prod_lo_r[j];
        end
      end
    end
  end

  // Stage 3: exact sums of the ordered terms
  sum_t sum_min_nxt;
  sum_t sum_max_nxt;
  assign sum_min_nxt = SUM_W'(term_min_r[0]) + SUM_W'(term_min_r[1]) + SUM_W'(term_min_r[2]);
  assign sum_max_nxt = SUM_W'(term_max_r[0]) + SUM_W'(term_max_r[1]) + SUM_W'(term_max_r[2]);

  always_ff @(posedge clk) begin
    if (en.en3) begin
      sum_min_r <= sum_min_nxt;
      sum_max_r <= sum_max_nxt;
    end
  end

  // Stage 4: drop fraction (floor), add translation, saturate
  logic signed [SH_W-1:0] sh_min;
  logic signed [SH_W-1:0] sh_max;
  add_t       add_min;
  add_t       add_max;
  clamp_res_t cl_min;
  clamp_res_t cl_max;

  assign sh_min  = SH_W'(sum_min_r >>> FRAC_W);
  assign sh_max  = SH_W'(sum_max_r >>> FRAC_W);
  assign add_min = ADD_W'(sh_min) + ADD_W'(shift);
  assign add_max = ADD_W'(sh_max) + ADD_W'(shift);
  assign cl_min  = clamp_coord(add_min);
  assign cl_max  = clamp_coord(add_max);

  always_ff @(posedge clk) begin
    if (en.en4) begin
      res_min_r <= cl_min.val;
      res_max_r <= cl_max.val;
      res_sat_r <= cl_min.sat | cl_max.sat;
    end
  end

  assign res_min = res_min_r;
  assign res_max = res_max_r;
  assign res_sat = res_sat_r;

endmodule
`default_nettype wire
